// ===== design/fdmm_pkg.sv =====
package fdmm_pkg;

   // default sizing
   localparam int WINDOW_DEPTH_DEF = 256;
   localparam int TIME_BITS_DEF    = 48;

   // field widths
   localparam int ACT_W   = 2;
   localparam int FLD_W   = 48;
   localparam int WIN_W   = 24;
   localparam int CNT_O_W = 9;
   localparam int FPS_W   = 24;

   // action codes
   localparam logic [ACT_W-1:0] ACT_RECORD = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REPORT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 24'd1000000;
   localparam longint unsigned  ONE_SECOND_US = 64'd1000000;
   // one second in microseconds times 256 (q8 scaling of fps)
   localparam int               FPS_SCALE_W = 28;
   localparam logic [FPS_SCALE_W-1:0] FPS_SCALE = 28'd256000000;
   localparam logic [FPS_W-1:0] FPS_MAX = '1;
   localparam logic [FLD_W-1:0] FLD_MAX = '1;

   function automatic logic [FLD_W-1:0] sat_add48(input logic [FLD_W-1:0] a,
                                                  input logic [FLD_W-1:0] b);
      logic [FLD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FLD_W] ? FLD_MAX : s[FLD_W-1:0];
   endfunction

endpackage

// ===== design/fdmm_ifs.sv =====
interface fdmm_req_if;
   logic                           valid;
   logic                           ready;
   logic [fdmm_pkg::ACT_W-1:0]     action;
   logic [fdmm_pkg::FLD_W-1:0]     frame_index;
   logic [fdmm_pkg::FLD_W-1:0]     frame_capture_us;
   logic [fdmm_pkg::FLD_W-1:0]     event_time_us;

   modport source (output valid, action, frame_index, frame_capture_us, event_time_us,
                   input ready);
   modport sink   (input valid, action, frame_index, frame_capture_us, event_time_us,
                   output ready);
endinterface

interface fdmm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           report_valid;
   logic [fdmm_pkg::CNT_O_W-1:0]   sample_count;
   logic [fdmm_pkg::FPS_W-1:0]     display_fps_q8;
   logic [fdmm_pkg::FLD_W-1:0]     avg_latency_us;
   logic [fdmm_pkg::FLD_W-1:0]     total_drops;
   logic [fdmm_pkg::FLD_W-1:0]     window_skips;

   modport source (output valid, report_valid, sample_count, display_fps_q8,
                   avg_latency_us, total_drops, window_skips, input ready);
   modport sink   (input valid, report_valid, sample_count, display_fps_q8,
                   avg_latency_us, total_drops, window_skips, output ready);
endinterface

// ===== design/fdmm_ring.sv =====
module fdmm_ring #(
   parameter int DEPTH = fdmm_pkg::WINDOW_DEPTH_DEF,
   parameter int ENT_W = 3 * fdmm_pkg::FLD_W
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [ENT_W-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [ENT_W-1:0]                          rd_data
);
   logic [ENT_W-1:0] mem [DEPTH];
   logic [ENT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/fdmm_div.sv =====
module fdmm_div #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo
);
   localparam int CW = $clog2(W + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    shifted;
   logic          fits;

   // one quotient bit per cycle, restoring; hold the divisor taken at start
   assign shifted = {rem_ff, quo_ff[W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(W);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (run_ff) begin
         rem_in = fits ? W'(shifted - {1'b0, den_ff}) : shifted[W-1:0];
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

// ===== design/frame_display_metrics_monitor.sv =====
// Frame display metrics monitor. Keeps a ring of up to WINDOW_DEPTH displayed-frame
// samples (display time, capture time, frame index) and evicts those older than
// the window length written through csr_wr_en/csr_wr_data (reset value one second).
// Action 0 records a sample, 1 returns one report transaction (count, fps in q8,
// mean latency, total and in-window drops), 2 clears the metrics, 3 is ignored.
// The block takes one transaction at a time and drops req.ready while it works.
// Sample memory reads are registered (single read port), so each entry a record
// evicts and each entry a report walks takes a read state and a compare or
// accumulate state. Both report divisions run one quotient bit per cycle on a
// single shared restoring divider. A finished report waits in the output
// register until rsp.ready.
module frame_display_metrics_monitor #(
   parameter int WINDOW_DEPTH = fdmm_pkg::WINDOW_DEPTH_DEF,
   parameter int TIME_BITS    = fdmm_pkg::TIME_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [fdmm_pkg::WIN_W-1:0] csr_wr_data,
   fdmm_req_if.sink                   req,
   fdmm_rsp_if.source                 rsp
);
   localparam int FW    = fdmm_pkg::FLD_W;
   localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int TW    = TIME_BITS;
   localparam int LW    = (TW > FW) ? TW : FW;          // latency arithmetic width
   localparam int SUM_W = LW + CNT_W;                    // latency sum, never wraps
   localparam int NUM_W = CNT_W + fdmm_pkg::FPS_SCALE_W; // count * 256e6
   localparam int DIV_W = SUM_W;
   localparam int ENT_W = TW + 2 * FW;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EV_RD  = 4'd1;
   localparam logic [3:0] S_EV_CMP = 4'd2;
   localparam logic [3:0] S_REC    = 4'd3;
   localparam logic [3:0] S_RP_CHK = 4'd4;
   localparam logic [3:0] S_W_RD   = 4'd5;
   localparam logic [3:0] S_W_ACC  = 4'd6;
   localparam logic [3:0] S_FPS    = 4'd7;
   localparam logic [3:0] S_DIV_F  = 4'd8;
   localparam logic [3:0] S_LAT    = 4'd9;
   localparam logic [3:0] S_DIV_L  = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   // control state
   logic [3:0]                   state_ff, state_in;
   logic [fdmm_pkg::WIN_W-1:0]   win_ff;
   logic [AW-1:0]                head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [FW-1:0]                last_ff, last_in;
   logic                         seen_ff, seen_in;
   logic [FW-1:0]                total_ff, total_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // working registers of the current transaction
   logic [fdmm_pkg::ACT_W-1:0]   act_ff, act_in;
   logic [FW-1:0]                idx_ff, idx_in;
   logic [FW-1:0]                cap_ff, cap_in;
   logic [TW-1:0]                t_ff, t_in;
   logic [AW-1:0]                ptr_ff, ptr_in;
   logic [CNT_W-1:0]             k_ff, k_in;
   logic [TW-1:0]                start_ff, start_in;
   logic [TW-1:0]                end_ff, end_in;
   logic [FW-1:0]                prev_ff, prev_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [FW-1:0]                wd_ff, wd_in;
   logic [fdmm_pkg::FPS_W-1:0]   fps_ff, fps_in;
   logic [FW-1:0]                lat_ff, lat_in;
   logic                         rep_ok_ff, rep_ok_in;

   // result register
   logic                         o_rv_ff, o_rv_in;
   logic [fdmm_pkg::CNT_O_W-1:0] o_cnt_ff, o_cnt_in;
   logic [fdmm_pkg::FPS_W-1:0]   o_fps_ff, o_fps_in;
   logic [FW-1:0]                o_lat_ff, o_lat_in;
   logic [FW-1:0]                o_tot_ff, o_tot_in;
   logic [FW-1:0]                o_wd_ff, o_wd_in;

   // memory and divider hookup
   logic                         wr_en, rd_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [ENT_W-1:0]             wr_data, rd_data;
   logic [TW-1:0]                rd_disp;
   logic [FW-1:0]                rd_cap, rd_idx;
   logic                         div_start, div_done;
   logic [DIV_W-1:0]             div_num, div_den, div_quo;

   // derived values
   logic [TW-1:0]                age;
   logic [FW-1:0]                rec_gap, win_gap;
   logic [LW-1:0]                lat_disp, lat_cap;
   logic [AW:0]                  tail_sum;
   logic [AW-1:0]                tail_addr;
   logic                         full;
   logic [CNT_W-1:0]             last_k;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign rd_disp  = rd_data[ENT_W-1 -: TW];
   assign rd_cap   = rd_data[2*FW-1:FW];
   assign rd_idx   = rd_data[FW-1:0];
   assign age      = t_ff - rd_disp;
   assign rec_gap  = idx_ff - last_ff;
   assign win_gap  = rd_idx - prev_ff;
   assign lat_disp = LW'(rd_disp);
   assign lat_cap  = LW'(rd_cap);
   assign full     = count_ff == CNT_W'(WINDOW_DEPTH);
   assign last_k   = count_ff - CNT_W'(1);
   assign tail_sum = (AW+1)'(head_ff) + (AW+1)'(count_ff);
   assign tail_addr = (tail_sum >= (AW+1)'(WINDOW_DEPTH))
                      ? AW'(tail_sum - (AW+1)'(WINDOW_DEPTH)) : tail_sum[AW-1:0];

   assign req.ready = state_ff == S_IDLE;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      total_in     = total_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      cap_in       = cap_ff;
      t_in         = t_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      prev_in      = prev_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      wd_in        = wd_ff;
      fps_in       = fps_ff;
      lat_in       = lat_ff;
      rep_ok_in    = rep_ok_ff;
      o_rv_in      = o_rv_ff;
      o_cnt_in     = o_cnt_ff;
      o_fps_in     = o_fps_ff;
      o_lat_in     = o_lat_ff;
      o_tot_in     = o_tot_ff;
      o_wd_in      = o_wd_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_addr;
      wr_data      = {t_ff, cap_ff, idx_ff};
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      div_start    = 1'b0;
      div_num      = DIV_W'(sum_ff);
      div_den      = DIV_W'(n_ff);
      // drop the result once the sink takes it
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               act_in = req.action;
               idx_in = req.frame_index;
               cap_in = req.frame_capture_us;
               t_in   = TW'(req.event_time_us);
               case (req.action)
                  fdmm_pkg::ACT_RECORD, fdmm_pkg::ACT_REPORT: begin
                     state_in = S_EV_RD;
                  end
                  fdmm_pkg::ACT_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                     last_in  = '0;
                     seen_in  = 1'b0;
                     total_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // eviction: fetch the oldest entry, then compare its age
         S_EV_RD: begin
            if (count_ff == '0) begin
               state_in = (act_ff == fdmm_pkg::ACT_RECORD) ? S_REC : S_RP_CHK;
            end else begin
               rd_en    = 1'b1;
               state_in = S_EV_CMP;
            end
         end
         S_EV_CMP: begin
            if (age > TW'(win_ff)) begin
               head_in  = nxt(head_ff);
               count_in = count_ff - CNT_W'(1);
               state_in = S_EV_RD;
            end else begin
               state_in = (act_ff == fdmm_pkg::ACT_RECORD) ? S_REC : S_RP_CHK;
            end
         end
         S_REC: begin
            if (seen_ff && idx_ff > last_ff && rec_gap > FW'(1)) begin
               total_in = fdmm_pkg::sat_add48(total_ff, rec_gap - FW'(1));
            end
            seen_in = 1'b1;
            last_in = idx_ff;
            wr_en   = 1'b1;
            // a full ring overwrites its oldest slot and advances the head
            if (full) begin
               wr_addr = head_ff;
               head_in = nxt(head_ff);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = S_IDLE;
         end
         S_RP_CHK: begin
            ptr_in    = head_ff;
            k_in      = '0;
            n_in      = '0;
            sum_in    = '0;
            wd_in     = '0;
            fps_in    = '0;
            lat_in    = '0;
            rep_ok_in = count_ff != '0;
            state_in  = (count_ff == '0) ? S_OUT : S_W_RD;
         end
         // walk the window oldest first
         S_W_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff;
            state_in = S_W_ACC;
         end
         S_W_ACC: begin
            if (k_ff == '0) begin
               start_in = rd_disp;
            end
            if (k_ff == last_k) begin
               end_in = rd_disp;
            end
            if (lat_disp >= lat_cap) begin
               n_in   = n_ff + CNT_W'(1);
               sum_in = sum_ff + SUM_W'(lat_disp - lat_cap);
            end
            if (k_ff != '0 && rd_idx > prev_ff && win_gap > FW'(1)) begin
               wd_in = fdmm_pkg::sat_add48(wd_ff, win_gap - FW'(1));
            end
            prev_in  = rd_idx;
            ptr_in   = nxt(ptr_ff);
            k_in     = k_ff + CNT_W'(1);
            state_in = (k_ff == last_k) ? S_FPS : S_W_RD;
         end
         S_FPS: begin
            div_start = 1'b1;
            div_num   = DIV_W'(NUM_W'(count_ff) * NUM_W'(fdmm_pkg::FPS_SCALE));
            div_den   = (end_ff > start_ff) ? DIV_W'(end_ff - start_ff)
                                            : DIV_W'(fdmm_pkg::ONE_SECOND_US);
            state_in  = S_DIV_F;
         end
         S_DIV_F: begin
            if (div_done) begin
               fps_in   = (div_quo > DIV_W'(fdmm_pkg::FPS_MAX))
                          ? fdmm_pkg::FPS_MAX : div_quo[fdmm_pkg::FPS_W-1:0];
               state_in = S_LAT;
            end
         end
         S_LAT: begin
            if (n_ff == '0) begin
               state_in = S_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_L;
            end
         end
         S_DIV_L: begin
            if (div_done) begin
               lat_in   = (div_quo > DIV_W'(fdmm_pkg::FLD_MAX))
                          ? fdmm_pkg::FLD_MAX : div_quo[FW-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               o_rv_in      = rep_ok_ff;
               o_cnt_in     = fdmm_pkg::CNT_O_W'(count_ff);
               o_fps_in     = fps_ff;
               o_lat_in     = lat_ff;
               o_tot_in     = total_ff;
               o_wd_in      = wd_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_ff       <= fdmm_pkg::WINDOW_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            win_ff <= csr_wr_data;
         end
         head_ff      <= head_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      idx_ff    <= idx_in;
      cap_ff    <= cap_in;
      t_ff      <= t_in;
      ptr_ff    <= ptr_in;
      k_ff      <= k_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      prev_ff   <= prev_in;
      n_ff      <= n_in;
      sum_ff    <= sum_in;
      wd_ff     <= wd_in;
      fps_ff    <= fps_in;
      lat_ff    <= lat_in;
      rep_ok_ff <= rep_ok_in;
      o_rv_ff   <= o_rv_in;
      o_cnt_ff  <= o_cnt_in;
      o_fps_ff  <= o_fps_in;
      o_lat_ff  <= o_lat_in;
      o_tot_ff  <= o_tot_in;
      o_wd_ff   <= o_wd_in;
   end

   fdmm_ring #(
      .DEPTH (WINDOW_DEPTH),
      .ENT_W (ENT_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fdmm_div #(
      .W (DIV_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.report_valid   = o_rv_ff;
   assign rsp.sample_count   = o_cnt_ff;
   assign rsp.display_fps_q8 = o_fps_ff;
   assign rsp.avg_latency_us = o_lat_ff;
   assign rsp.total_drops    = o_tot_ff;
   assign rsp.window_skips   = o_wd_ff;
endmodule

// ===== design/fdmm_checker.sv =====
module fdmm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [fdmm_pkg::ACT_W-1:0]         req_action,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_report_valid,
   input logic [fdmm_pkg::CNT_O_W-1:0]       rsp_sample_count,
   input logic [fdmm_pkg::FPS_W-1:0]         rsp_display_fps_q8,
   input logic [fdmm_pkg::FLD_W-1:0]         rsp_avg_latency_us,
   input logic [fdmm_pkg::FLD_W-1:0]         rsp_window_skips
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_report_valid)
         && $stable(rsp_sample_count) && $stable(rsp_avg_latency_us))
      else $error("report transaction changed while stalled");

   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_sample_count == '0
         && rsp_display_fps_q8 == '0 && rsp_avg_latency_us == '0
         && rsp_window_skips == '0)
      else $error("empty report carries nonzero metrics");

   a_full_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_valid |-> rsp_sample_count != '0)
      else $error("valid report with no samples");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == fdmm_pkg::ACT_REPORT |=> !req_ready)
      else $error("report transaction did not occupy the block");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("report pending after reset");
endmodule

bind frame_display_metrics_monitor fdmm_checker u_fdmm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .req_action         (req.action),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_report_valid   (rsp.report_valid),
   .rsp_sample_count   (rsp.sample_count),
   .rsp_display_fps_q8 (rsp.display_fps_q8),
   .rsp_avg_latency_us (rsp.avg_latency_us),
   .rsp_window_skips   (rsp.window_skips)
);

// ===== dv/frame_display_metrics_monitor_test.sv =====
module frame_display_metrics_monitor_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     DEPTH       = 256;
   localparam int     SETTLE      = 800;      // longer than the longest report
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [fdmm_pkg::ACT_W-1:0] action;
      logic [fdmm_pkg::FLD_W-1:0] frame_index;
      logic [fdmm_pkg::FLD_W-1:0] capture_us;
      logic [fdmm_pkg::FLD_W-1:0] event_us;
   } frame_txn_type;

   typedef struct {
      logic                         report_valid;
      logic [fdmm_pkg::CNT_O_W-1:0] sample_count;
      logic [fdmm_pkg::FPS_W-1:0]   fps_q8;
      logic [fdmm_pkg::FLD_W-1:0]   avg_latency;
      logic [fdmm_pkg::FLD_W-1:0]   total_drops;
      logic [fdmm_pkg::FLD_W-1:0]   window_skips;
   } metrics_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [fdmm_pkg::WIN_W-1:0] csr_wr_data;

   fdmm_req_if req ();
   fdmm_rsp_if rsp ();

   frame_display_metrics_monitor DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req.sink),
      .rsp         (rsp.source)
   );

   // stimulus and scoreboard storage
   frame_txn_type pending_frames[$];
   metrics_type   expected_reports[$];
   int         errors = 0;
   int         sender_idle_pct = 0;
   int         receiver_idle_pct = 0;
   bit         sender_hold = 0;
   bit         stall_request = 0;
   bit         frame_taken = 0;
   longint     cycle_count = 0;

   // shadow of the window ring and drop bookkeeping
   logic [fdmm_pkg::WIN_W-1:0] win_len;
   logic [fdmm_pkg::FLD_W-1:0] shadow_disp[DEPTH];
   logic [fdmm_pkg::FLD_W-1:0] shadow_capt[DEPTH];
   logic [fdmm_pkg::FLD_W-1:0] shadow_idx[DEPTH];
   int                         shadow_head;
   int                         shadow_count;
   logic [fdmm_pkg::FLD_W-1:0] shadow_last_idx;
   bit                         shadow_seen;
   logic [fdmm_pkg::FLD_W-1:0] shadow_drop_total;

   // random sequence state
   logic [fdmm_pkg::FLD_W-1:0] seq_time;
   logic [fdmm_pkg::FLD_W-1:0] seq_index;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [fdmm_pkg::FLD_W-1:0] clamp_add(logic [fdmm_pkg::FLD_W-1:0] a,
                                                            logic [fdmm_pkg::FLD_W-1:0] b);
      logic [fdmm_pkg::FLD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[fdmm_pkg::FLD_W] ? {fdmm_pkg::FLD_W{1'b1}} : s[fdmm_pkg::FLD_W-1:0];
   endfunction

   function automatic int ring_slot(int k);
      return (shadow_head + k) % DEPTH;
   endfunction

   function automatic void clear_shadow();
      shadow_head       = 0;
      shadow_count      = 0;
      shadow_last_idx   = '0;
      shadow_seen       = 0;
      shadow_drop_total = '0;
   endfunction

   // retire entries whose wrapped age exceeds the window
   function automatic void age_out(logic [fdmm_pkg::FLD_W-1:0] now);
      logic [fdmm_pkg::FLD_W-1:0] age;
      while (shadow_count > 0) begin
         age = now - shadow_disp[shadow_head];
         if (age <= {24'd0, win_len}) break;
         shadow_head  = ring_slot(1);
         shadow_count = shadow_count - 1;
      end
   endfunction

   function automatic void apply_frame(frame_txn_type t);
      metrics_type                m;
      int                         p, n;
      longint unsigned            span, fps, lat_sum;
      logic [fdmm_pkg::FLD_W-1:0] a, b, first_t, last_t;
      case (t.action)
         fdmm_pkg::ACT_RECORD: begin
            age_out(t.event_us);
            if (shadow_seen) begin
               if (t.frame_index > shadow_last_idx && t.frame_index - shadow_last_idx > 1)
                  shadow_drop_total = clamp_add(shadow_drop_total,
                                                t.frame_index - shadow_last_idx - 1);
            end else begin
               shadow_seen = 1;
            end
            if (shadow_count >= DEPTH) begin
               shadow_head  = ring_slot(1);
               shadow_count = shadow_count - 1;
            end
            p = ring_slot(shadow_count);
            shadow_disp[p]  = t.event_us;
            shadow_capt[p]  = t.capture_us;
            shadow_idx[p]   = t.frame_index;
            shadow_count    = shadow_count + 1;
            shadow_last_idx = t.frame_index;
         end
         fdmm_pkg::ACT_REPORT: begin
            age_out(t.event_us);
            m = '{default: '0};
            m.total_drops = shadow_drop_total;
            if (shadow_count > 0) begin
               first_t = shadow_disp[shadow_head];
               last_t  = shadow_disp[ring_slot(shadow_count - 1)];
               span = (last_t > first_t) ? longint'(last_t - first_t)
                                         : fdmm_pkg::ONE_SECOND_US;
               fps  = (longint'(shadow_count) * 64'd256000000) / span;
               m.fps_q8 = (fps > 64'hFFFFFF) ? fdmm_pkg::FPS_MAX : fps[fdmm_pkg::FPS_W-1:0];
               n = 0;
               lat_sum = 0;
               for (int k = 0; k < shadow_count; k++) begin
                  p = ring_slot(k);
                  if (shadow_disp[p] >= shadow_capt[p]) begin
                     n++;
                     lat_sum += longint'(shadow_disp[p] - shadow_capt[p]);
                  end
               end
               if (n > 0) m.avg_latency = fdmm_pkg::FLD_W'(lat_sum / n);
               for (int k = 1; k < shadow_count; k++) begin
                  a = shadow_idx[ring_slot(k - 1)];
                  b = shadow_idx[ring_slot(k)];
                  if (b > a && b - a > 1) m.window_skips = clamp_add(m.window_skips, b - a - 1);
               end
               m.report_valid = 1;
               m.sample_count = fdmm_pkg::CNT_O_W'(shadow_count);
            end
            expected_reports.insert(expected_reports.size(), m);
         end
         fdmm_pkg::ACT_CLEAR: clear_shadow();
         default: ;   // code 3 is ignored
      endcase
   endfunction

   function automatic logic [fdmm_pkg::FLD_W-1:0] rand_field();
      return fdmm_pkg::FLD_W'({$urandom, $urandom});
   endfunction

   function automatic void add_frame(logic [fdmm_pkg::ACT_W-1:0] act,
                                     logic [fdmm_pkg::FLD_W-1:0] idx,
                                     logic [fdmm_pkg::FLD_W-1:0] cap,
                                     logic [fdmm_pkg::FLD_W-1:0] t);
      frame_txn_type f;
      f.action      = act;
      f.frame_index = idx;
      f.capture_us  = cap;
      f.event_us    = t;
      pending_frames.insert(pending_frames.size(), f);
   endfunction

   // mostly well-formed display streams, with some noise mixed in
   task automatic queue_stream(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 70) begin
            seq_time  += $urandom_range(20000, 1000);
            seq_index += ($urandom_range(99) < 85) ? 1 : $urandom_range(50, 2);
            if ($urandom_range(99) < 5)
               add_frame(fdmm_pkg::ACT_RECORD, seq_index,
                         seq_time + $urandom_range(5000, 1), seq_time);
            else
               add_frame(fdmm_pkg::ACT_RECORD, seq_index,
                         seq_time - $urandom_range(60000, 0), seq_time);
         end else if (r < 88) begin
            seq_time += $urandom_range(30000, 0);
            add_frame(fdmm_pkg::ACT_REPORT, rand_field(), rand_field(), seq_time);
         end else if (r < 92) begin
            add_frame(fdmm_pkg::ACT_RECORD, rand_field(), rand_field(), rand_field());
         end else if (r < 95) begin
            add_frame(fdmm_pkg::ACT_CLEAR, rand_field(), rand_field(), rand_field());
         end else if (r < 97) begin
            add_frame(2'd3, rand_field(), rand_field(), rand_field());
         end else begin
            add_frame(fdmm_pkg::ACT_REPORT, rand_field(), rand_field(), rand_field());
         end
      end
   endtask

   // wait for the block to drain, then write the window length while idle
   task automatic set_window(logic [fdmm_pkg::WIN_W-1:0] value);
      wait (pending_frames.size() == 0 && expected_reports.size() == 0);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      win_len = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      end
   endtask

   // driver: advance to the next pending transaction once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || frame_taken) begin
         frame_taken = 0;
         if (pending_frames.size() > 0 && !sender_hold &&
             $urandom_range(99) >= sender_idle_pct) begin
            req.valid            <= 1'b1;
            req.action           <= pending_frames[0].action;
            req.frame_index      <= pending_frames[0].frame_index;
            req.frame_capture_us <= pending_frames[0].capture_us;
            req.event_time_us    <= pending_frames[0].event_us;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // accepted requests feed the predictor
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         apply_frame(pending_frames[0]);
         pending_frames.delete(0);
         frame_taken = 1;
      end
   end

   // receiver: random back-pressure plus a long hold-off when requested
   int hold_left = 0;
   always @(negedge clock) begin
      if (stall_request) begin
         stall_request = 0;
         hold_left     = 4000;
      end
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // monitor: compare each report transaction with the oldest expectation
   always @(posedge clock) begin
      metrics_type m;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected report transaction, expected none, actual count %0d",
                     $realtime, rsp.sample_count);
         end else begin
            m = expected_reports[0];
            expected_reports.delete(0);
            check_field("report_valid", m.report_valid, rsp.report_valid);
            check_field("sample_count", m.sample_count, rsp.sample_count);
            check_field("display_fps_q8", m.fps_q8, rsp.display_fps_q8);
            check_field("avg_latency_us", m.avg_latency, rsp.avg_latency_us);
            check_field("total_drops", m.total_drops, rsp.total_drops);
            check_field("window_skips", m.window_skips, rsp.window_skips);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req.valid = 1'b0;
      req.action = '0;
      req.frame_index = '0;
      req.frame_capture_us = '0;
      req.event_time_us = '0;
      rsp.ready = 1'b0;
      win_len = fdmm_pkg::WINDOW_RESET;
      clear_shadow();
      seq_time  = 48'd5000000;
      seq_index = 48'd100;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: sender idles rarely, receiver often
      sender_idle_pct = 13;
      receiver_idle_pct = 86;
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 0);                          // empty window
      add_frame(fdmm_pkg::ACT_RECORD, 48'd10, 0, 0);                     // first sample
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 0);                          // one-second span
      add_frame(fdmm_pkg::ACT_RECORD, 48'd15, 48'd100, 48'd1000);        // gap of four
      add_frame(fdmm_pkg::ACT_RECORD, 48'd12, 48'd3000, 48'd2000);       // index back
      add_frame(fdmm_pkg::ACT_RECORD, 48'd13, 48'd500, 48'd3000);
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 48'd3000);
      add_frame(2'd3, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX); // ignored
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 48'd500);                    // time backwards
      add_frame(fdmm_pkg::ACT_RECORD, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX);
      add_frame(fdmm_pkg::ACT_RECORD, fdmm_pkg::FLD_MAX, 0, fdmm_pkg::FLD_MAX);
      add_frame(fdmm_pkg::ACT_REPORT, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX);
      add_frame(fdmm_pkg::ACT_RECORD, 0, 0, 48'd999);                    // wraps past zero
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 48'd1000);
      add_frame(fdmm_pkg::ACT_CLEAR, 0, 0, 0);
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 48'd1000);                   // empty after clear
      add_frame(fdmm_pkg::ACT_RECORD, 48'd1, 0, 48'd100);
      add_frame(fdmm_pkg::ACT_RECORD, fdmm_pkg::FLD_MAX, 0, 48'd200);    // huge gap
      add_frame(fdmm_pkg::ACT_RECORD, 48'd7, 48'd150, 48'd300);
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 48'd1000300);                // at window edge
      add_frame(fdmm_pkg::ACT_REPORT, 0, 0, 48'd1000301);
      add_frame(fdmm_pkg::ACT_CLEAR, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX, fdmm_pkg::FLD_MAX);

      set_window(24'hFFFFFF);
      queue_stream(150);
      stall_request = 1;                     // long receiver hold-off fills the block
      queue_stream(150);
      set_window(24'd1);
      queue_stream(200);

      // receiver rarely idles, sender often
      sender_idle_pct = 86;
      receiver_idle_pct = 13;
      set_window(24'd50000);
      queue_stream(200);
      set_window(fdmm_pkg::WIN_W'($urandom_range(24'hFFFFFF, 1)));
      queue_stream(150);
      // sender pauses until every report has arrived
      wait (pending_frames.size() == 0);
      sender_hold = 1;
      wait (expected_reports.size() == 0);
      sender_hold = 0;
      queue_stream(150);

      // no idling
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_window(fdmm_pkg::WINDOW_RESET);
      queue_stream(300);
      set_window(24'hFFFFFF);
      queue_stream(250);

      wait (pending_frames.size() == 0 && expected_reports.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && expected_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== frame_display_metrics_monitor.f =====
design/fdmm_pkg.sv
design/fdmm_ifs.sv
design/fdmm_ring.sv
design/fdmm_div.sv
design/frame_display_metrics_monitor.sv
design/fdmm_checker.sv
dv/frame_display_metrics_monitor_test.sv
